[rtl/core/lps_pkg.sv]
// Shared types, constants, pattern tables and microcode table for the LED pattern sequencer.
`timescale 1ns / 1ps

package lps_pkg;

   // Command codes carried in the input tuser
   localparam logic [1:0] CMD_TICK  = 2'd0;
   localparam logic [1:0] CMD_SET   = 2'd1;
   localparam logic [1:0] CMD_FLASH = 2'd2;

   // Pattern codes
   localparam logic [1:0] PAT_OFF    = 2'd0;
   localparam logic [1:0] PAT_SOLID  = 2'd1;
   localparam logic [1:0] PAT_DOUBLE = 2'd2;
   localparam logic [1:0] PAT_FLASH  = 2'd3;

   // Phase lengths in milliseconds
   localparam logic [9:0] MS_STEADY = 10'd100;
   localparam logic [9:0] MS_BLINK  = 10'd80;
   localparam logic [9:0] MS_PAUSE  = 10'd560;
   localparam logic [9:0] MS_FLASH  = 10'd110;

   // Pin levels (active low)
   localparam logic LED_LIT  = 1'b0;
   localparam logic LED_DARK = 1'b1;

   typedef enum logic [3:0] {
      ST_WAIT,
      ST_DISPATCH,
      ST_STEP,
      ST_ADVANCE,
      ST_CLOSE,
      ST_DRAIN,
      ST_START,
      ST_LOAD,
      ST_EMIT
   } step_type;

   typedef enum logic [3:0] {
      UOP_FETCH,
      UOP_NOP,
      UOP_COUNT,
      UOP_NEXT_PHASE,
      UOP_CLOSE,
      UOP_DRAIN,
      UOP_START,
      UOP_LOAD_PHASE,
      UOP_EMIT
   } uop_type;

   typedef enum logic [2:0] {
      COND_NEVER,
      COND_NO_ITEM,
      COND_COMMAND,
      COND_MS_LEFT,
      COND_WRAP,
      COND_QUEUED,
      COND_OUT_FULL
   } cond_type;

   // One control word: operation, jump condition, jump target, fall-through step
   typedef struct packed {
      uop_type  op;
      cond_type cond;
      step_type jump;
      step_type next;
   } ucode_type;

   // Microcode program
   function automatic ucode_type ucode_rom(input step_type s);
      ucode_type w;
      case (s)
         ST_WAIT:     w = '{UOP_FETCH,      COND_NO_ITEM,  ST_WAIT,  ST_DISPATCH};
         ST_DISPATCH: w = '{UOP_NOP,        COND_COMMAND,  ST_EMIT,  ST_STEP};
         ST_STEP:     w = '{UOP_COUNT,      COND_MS_LEFT,  ST_EMIT,  ST_ADVANCE};
         ST_ADVANCE:  w = '{UOP_NEXT_PHASE, COND_WRAP,     ST_CLOSE, ST_LOAD};
         ST_CLOSE:    w = '{UOP_CLOSE,      COND_NEVER,    ST_DRAIN, ST_DRAIN};
         ST_DRAIN:    w = '{UOP_DRAIN,      COND_QUEUED,   ST_DRAIN, ST_START};
         ST_START:    w = '{UOP_START,      COND_NEVER,    ST_LOAD,  ST_LOAD};
         ST_LOAD:     w = '{UOP_LOAD_PHASE, COND_NEVER,    ST_EMIT,  ST_EMIT};
         ST_EMIT:     w = '{UOP_EMIT,       COND_OUT_FULL, ST_EMIT,  ST_WAIT};
         default:     w = '{UOP_NOP,        COND_NEVER,    ST_WAIT,  ST_WAIT};
      endcase
      return w;
   endfunction

   // Number of phases in one cycle of a pattern
   function automatic logic [2:0] phase_count(input logic [1:0] pat);
      logic [2:0] n;
      case (pat)
         PAT_DOUBLE: n = 3'd4;
         PAT_FLASH:  n = 3'd2;
         default:    n = 3'd1;
      endcase
      return n;
   endfunction

   // Phase length less one, as loaded into the millisecond counter
   function automatic logic [9:0] phase_len_m1(input logic [1:0] pat, input logic [1:0] idx);
      logic [9:0] len;
      case (pat)
         PAT_DOUBLE: len = (idx == 2'd3) ? MS_PAUSE : MS_BLINK;
         PAT_FLASH:  len = MS_FLASH;
         default:    len = MS_STEADY;
      endcase
      return len - 10'd1;
   endfunction

   // Pin level of a phase
   function automatic logic led_of(input logic [1:0] pat, input logic [1:0] idx);
      logic lvl;
      case (pat)
         PAT_SOLID:  lvl = LED_LIT;
         PAT_DOUBLE: lvl = (idx == 2'd0 || idx == 2'd2) ? LED_LIT : LED_DARK;
         PAT_FLASH:  lvl = (idx == 2'd0) ? LED_LIT : LED_DARK;
         default:    lvl = LED_DARK;
      endcase
      return lvl;
   endfunction

endpackage

[rtl/core/led_pattern_sequencer_core.sv]
// LED pattern sequencer: microcoded control over pattern timers and a command queue.
`timescale 1ns / 1ps

// Plays an active-low LED pattern (off, solid, double blink, fast flash) one millisecond
// per tick word and queues set-pattern and flash-burst commands, which are applied in order
// only at the end of a pattern cycle. Every input word yields one result word. A step counter
// walks a small microcode table, one control word per cycle. A command goes from dispatch
// to emit, a tick inside a phase counts and emits, a tick that ends a phase also advances
// and loads the next, and a tick at a cycle end also closes the cycle, drains the queued
// commands (one per cycle through the single queue read port) and starts the next. A new
// word is taken only once the previous one has left the step counter; a result waiting on
// rsp_tready stalls only the final step. There is no clearing pass after reset.
module led_pattern_sequencer_core
   import lps_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // [1:0] command
   input  logic [15:0] req_tdata,   // [1:0] pattern_sel, [9:2] flash_count, [15:10] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // [0] led_level, [2:1] shown_pattern,
                                    // [10:3] flashes_left, [11] cmd_dropped, [15:12] zero
);

   localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [FW-1:0] FILL_MAX = FW'(QUEUE_DEPTH);
   localparam logic [IW-1:0] HEAD_LAST = IW'(QUEUE_DEPTH - 1);
   localparam logic [FW:0] SUM_WRAP = (FW + 1)'(QUEUE_DEPTH);

   // Step counter and registers
   step_type   upc_ff, upc_in;
   logic       item_cmd_ff, item_cmd_in;
   logic       dropped_ff, dropped_in;
   logic [1:0] persist_ff, persist_in;
   logic [1:0] restore_ff, restore_in;
   logic [7:0] transient_ff, transient_in;
   logic [1:0] playing_ff, playing_in;
   logic [1:0] phase_ff, phase_in;
   logic [9:0] ms_left_ff, ms_left_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic [IW-1:0] head_ff, head_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [11:0] rsp_data_ff, rsp_data_in;

   // Command queue, no reset
   logic [9:0] queue_ff [QUEUE_DEPTH];
   logic       queue_we;
   logic [IW-1:0] queue_wsel;
   logic [9:0] queue_wdata;
   logic [9:0] queue_rdata;

   ucode_type  uword;
   logic       cond_true;
   logic       accept;
   logic [FW:0] tail_sum;
   logic [1:0] req_cmd;
   logic [1:0] req_sel;
   logic [7:0] req_cnt;

   assign req_cmd = req_tuser;
   assign req_sel = req_tdata[1:0];
   assign req_cnt = req_tdata[9:2];

   assign uword      = ucode_rom(upc_ff);
   assign req_tready = (upc_ff == ST_WAIT);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_data_ff};
   assign queue_rdata = queue_ff[head_ff];

   // Tail slot: head plus fill, folded once into the queue range
   always_comb begin
      tail_sum = (FW + 1)'(head_ff) + (FW + 1)'(fill_ff);
      if (tail_sum >= SUM_WRAP) begin
         tail_sum = tail_sum - SUM_WRAP;
      end
      queue_wsel = tail_sum[IW-1:0];
   end

   // Evaluate the jump condition of the current control word
   always_comb begin
      case (uword.cond)
         COND_NO_ITEM:  cond_true = !accept;
         COND_COMMAND:  cond_true = item_cmd_ff;
         COND_MS_LEFT:  cond_true = (ms_left_ff != 10'd0);
         COND_WRAP:     cond_true = ({1'b0, phase_ff} + 3'd1) >= phase_count(playing_ff);
         COND_QUEUED:   cond_true = (fill_ff != '0);
         COND_OUT_FULL: cond_true = rsp_valid_ff && !rsp_tready;
         default:       cond_true = 1'b0;
      endcase
   end

   // Datapath driven by the control word
   always_comb begin
      upc_in       = cond_true ? uword.jump : uword.next;
      item_cmd_in  = item_cmd_ff;
      dropped_in   = dropped_ff;
      persist_in   = persist_ff;
      restore_in   = restore_ff;
      transient_in = transient_ff;
      playing_in   = playing_ff;
      phase_in     = phase_ff;
      ms_left_in   = ms_left_ff;
      fill_in      = fill_ff;
      head_in      = head_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      queue_we     = 1'b0;
      queue_wdata  = {PAT_FLASH, req_cnt};

      case (uword.op)
         // Take a word; queue a command or drop it when the queue is full
         UOP_FETCH: begin
            if (accept) begin
               item_cmd_in = (req_cmd != CMD_TICK);
               dropped_in  = 1'b0;
               if (req_cmd == CMD_SET || req_cmd == CMD_FLASH) begin
                  if (fill_ff >= FILL_MAX) begin
                     dropped_in = 1'b1;
                  end else begin
                     queue_we    = 1'b1;
                     queue_wdata = (req_cmd == CMD_SET) ? {req_sel, 8'd0} : {PAT_FLASH, req_cnt};
                     fill_in     = fill_ff + FW'(1);
                  end
               end
            end
         end
         // Consume one millisecond of a running phase
         UOP_COUNT: begin
            if (ms_left_ff != 10'd0) begin
               ms_left_in = ms_left_ff - 10'd1;
            end
         end
         UOP_NEXT_PHASE: begin
            phase_in = phase_ff + 2'd1;
         end
         // Close the finished cycle: count down a burst, restore at its end
         UOP_CLOSE: begin
            if (transient_ff != 8'd0) begin
               transient_in = transient_ff - 8'd1;
               if (transient_ff == 8'd1) begin
                  persist_in = restore_ff;
               end
            end
         end
         // Apply the queue head, one entry per cycle
         UOP_DRAIN: begin
            if (fill_ff != '0) begin
               fill_in = fill_ff - FW'(1);
               head_in = (head_ff == HEAD_LAST) ? '0 : head_ff + IW'(1);
               if (queue_rdata[7:0] != 8'd0) begin
                  transient_in = queue_rdata[7:0];
                  restore_in   = persist_ff;
               end else begin
                  transient_in = 8'd0;
                  persist_in   = queue_rdata[9:8];
               end
            end
         end
         UOP_START: begin
            playing_in = (transient_ff != 8'd0) ? PAT_FLASH : persist_ff;
            phase_in   = 2'd0;
         end
         UOP_LOAD_PHASE: begin
            ms_left_in = phase_len_m1(playing_ff, phase_ff);
         end
         // Hand the result to the output register once it is free
         UOP_EMIT: begin
            if (!(rsp_valid_ff && !rsp_tready)) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {dropped_ff, transient_ff, playing_ff, led_of(playing_ff, phase_ff)};
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff       <= ST_WAIT;
         item_cmd_ff  <= 1'b0;
         dropped_ff   <= 1'b0;
         persist_ff   <= PAT_OFF;
         restore_ff   <= PAT_OFF;
         transient_ff <= 8'd0;
         playing_ff   <= PAT_OFF;
         phase_ff     <= 2'd0;
         ms_left_ff   <= 10'd0;
         fill_ff      <= '0;
         head_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         upc_ff       <= upc_in;
         item_cmd_ff  <= item_cmd_in;
         dropped_ff   <= dropped_in;
         persist_ff   <= persist_in;
         restore_ff   <= restore_in;
         transient_ff <= transient_in;
         playing_ff   <= playing_in;
         phase_ff     <= phase_in;
         ms_left_ff   <= ms_left_in;
         fill_ff      <= fill_in;
         head_ff      <= head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   // Queue storage write
   always_ff @(posedge clock) begin
      if (queue_we) begin
         queue_ff[queue_wsel] <= queue_wdata;
      end
   end

   // Queue fill never passes its depth
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_MAX)
      else $error("queue fill beyond depth");

   // Each drain step with entries waiting removes exactly one
   a_drain_one: assert property (@(posedge clock) disable iff (reset)
      (upc_ff == ST_DRAIN && fill_ff != '0) |=> fill_ff == $past(fill_ff) - FW'(1))
      else $error("drain did not remove one entry");

   // A new result only comes from the emit step
   a_emit_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(upc_ff) == ST_EMIT)
      else $error("result raised outside emit step");

   // While waiting for a word the phase index lies inside the playing pattern
   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      (upc_ff == ST_WAIT) |-> ({1'b0, phase_ff} < phase_count(playing_ff)))
      else $error("phase index outside pattern");

endmodule
